@@ hw/rtl/blifo_pkg.sv @@
// Shared constants, codes and types for the bounded LIFO stack.
// No dependencies; imported by blifo_ram, blifo_ctrl and bounded_lifo_stack.
package blifo_pkg;

  // Stack depth, valid from 2 to 64.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the item ports.
  localparam int CMD_W    = 2;
  localparam int WORD_W   = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;

  // Compare width wide enough for both a slot and the fill count.
  localparam int CMP_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_MODIFY  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADINDEX  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Access request from the controller to the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ hw/rtl/blifo_ram.sv @@
// Entry memory of the stack: one write port, one read port, registered read.
// Depends on blifo_pkg for depth, widths and the request struct.
module blifo_ram (
  input  logic                                    clk_i,
  input  blifo_pkg::ram_req_t                     req_i,
  output logic               [blifo_pkg::WORD_W-1:0] rdata_o
);
  import blifo_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // Hold read data until the next read, so a stalled consumer loses nothing.
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/blifo_ctrl.sv @@
// Command sequencer of the stack: fill count, read pointer and result register.
// Depends on blifo_pkg; drives the request port of blifo_ram.
module blifo_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [blifo_pkg::CMD_W-1:0]     cmd_i,
  input  logic signed [blifo_pkg::WORD_W-1:0]    value_i,
  input  logic        [blifo_pkg::SLOT_W-1:0]    slot_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [blifo_pkg::STATUS_W-1:0]  status_o,
  output logic signed [blifo_pkg::WORD_W-1:0]    word_o,
  output logic        [blifo_pkg::POS_W-1:0]     position_o,
  output logic                                   last_o,
  output blifo_pkg::ram_req_t                    ram_req_o,
  input  logic        [blifo_pkg::WORD_W-1:0]    ram_rdata_i
);
  import blifo_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] ptr_q;
  logic              single_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [WORD_W-1:0] word_q;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;

  cmd_e              cmd;
  logic              out_free;
  logic              in_acc;
  logic              full;
  logic              empty;
  logic              slot_ok;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] ptr_m1;
  logic              rd_done;

  logic              load;
  status_e           st_d;
  logic [WORD_W-1:0] word_d;
  logic [POS_W-1:0]  pos_d;
  logic              last_d;

  assign cmd      = cmd_e'(cmd_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign slot_ok  = CMP_W'(slot_i) < CMP_W'(count_q);
  assign cnt_m1   = count_q - 1'b1;
  assign top_addr = cnt_m1[ADDR_W-1:0];
  assign ptr_m1   = ptr_q - 1'b1;
  assign rd_done  = single_q || (ptr_q == '0);

  // Memory access: writes only on an accepted item, reads at issue or advance.
  always_comb begin
    ram_req_o.we    = in_acc && (((cmd == CMD_PUSH) && !full) ||
                                 ((cmd == CMD_MODIFY) && slot_ok));
    ram_req_o.waddr = (cmd == CMD_PUSH) ? count_q[ADDR_W-1:0] : slot_i[ADDR_W-1:0];
    ram_req_o.wdata = value_i;
    ram_req_o.re    = (in_acc && ((cmd == CMD_POP) || (cmd == CMD_DISPLAY)) && !empty) ||
                      ((state_q == S_READ) && out_free && !rd_done);
    ram_req_o.raddr = (state_q == S_READ) ? ptr_m1 : top_addr;
  end

  // Result produced this cycle, if any.
  always_comb begin
    load   = 1'b0;
    st_d   = ST_OK;
    word_d = '0;
    pos_d  = '0;
    last_d = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_PUSH: begin
              load = 1'b1;
              if (full) begin
                st_d = ST_OVERFLOW;
              end else begin
                word_d = value_i;
                pos_d  = POS_W'(count_q[ADDR_W-1:0]);
              end
            end
            CMD_POP: begin
              if (empty) begin
                load = 1'b1;
                st_d = ST_UNDERFLOW;
              end
            end
            CMD_MODIFY: begin
              load = 1'b1;
              if (slot_ok) begin
                word_d = value_i;
                pos_d  = slot_i;
              end else begin
                st_d = ST_BADINDEX;
              end
            end
            CMD_DISPLAY: begin
              if (empty) begin
                load = 1'b1;
                st_d = ST_EMPTY;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load   = 1'b1;
          word_d = ram_rdata_i;
          pos_d  = POS_W'(ptr_q);
          last_d = rd_done;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      single_q    <= 1'b0;
    end else begin
      // Hold a stalled result; drop it once taken unless a new one loads.
      out_valid_q <= load || (out_valid_q && out_stall_i);
      if (load) begin
        status_q    <= st_d;
        word_q      <= word_d;
        pos_q       <= pos_d;
        last_q      <= last_d;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (cmd)
              CMD_PUSH: begin
                if (!full) begin
                  count_q <= count_q + 1'b1;
                end
              end
              CMD_POP: begin
                if (!empty) begin
                  count_q  <= cnt_m1;
                  ptr_q    <= top_addr;
                  single_q <= 1'b1;
                  state_q  <= S_READ;
                end
              end
              CMD_DISPLAY: begin
                if (!empty) begin
                  ptr_q    <= top_addr;
                  single_q <= 1'b0;
                  state_q  <= S_READ;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            if (rd_done) begin
              state_q <= S_IDLE;
            end else begin
              ptr_q <= ptr_m1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign word_o      = word_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !ram_req_o.we)
    else $error("memory write while streaming entries");

  a_mid_stream_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> ((status_q == ST_OK) && (pos_q != '0)))
    else $error("non-final result not an ok entry above the bottom");

endmodule

@@ hw/rtl/bounded_lifo_stack.sv @@
// Bounded LIFO stack of signed 32-bit words, DEPTH entries deep.
// Input channel (in_valid_i / in_stall_o) takes one item per command: cmd_i
// selects push, pop, modify or display, value_i and slot_i are its operands.
// Output channel (out_valid_o / out_stall_i) delivers result items with
// status_o, word_o, position_o and last_o; last_o marks the final result of
// a command. Push and modify write the entry memory on acceptance unless
// refused, and show their result in the next cycle. Pop and display of a
// non-empty stack read the memory through its registered read port, so
// their first result goes through the read data and result registers.
// Display then streams one entry per cycle from top to bottom while the
// receiver does not stall. Push, modify and error cases end on acceptance.
// The single read port sets the streaming rate. While a pop or display is
// in flight, in_stall_o holds the input. A stalled receiver holds the result
// register, which holds the input and the read pointer; no result is lost.
// Reset empties the stack (fill count zero) at once; entry contents are
// not cleared and need no clearing pass, since only pushed entries are read.
// Depends on blifo_pkg, blifo_ctrl and blifo_ram.
module bounded_lifo_stack (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [blifo_pkg::CMD_W-1:0]     cmd_i,
  input  logic signed [blifo_pkg::WORD_W-1:0]    value_i,
  input  logic        [blifo_pkg::SLOT_W-1:0]    slot_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [blifo_pkg::STATUS_W-1:0]  status_o,
  output logic signed [blifo_pkg::WORD_W-1:0]    word_o,
  output logic        [blifo_pkg::POS_W-1:0]     position_o,
  output logic                                   last_o
);
  import blifo_pkg::*;

  // Request bus from the sequencer to the entry memory, and its read data.
  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;

  // Sequencer: fill count, read pointer and the output register.
  blifo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .slot_i      (slot_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .word_o      (word_o),
    .position_o  (position_o),
    .last_o      (last_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Entry storage; reads and writes never target the same cycle's entry.
  blifo_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

@@ tb/bounded_lifo_stack_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bounded_lifo_stack: directed table, fill ramp, random mix.
// Depends on blifo_pkg and the bounded_lifo_stack RTL; needs nothing else.
module bounded_lifo_stack_tb;
  import blifo_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 25;

  // One result item as the block presents it.
  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   word;
    logic [POS_W-1:0]    position;
    logic                is_last;
  } stack_result_t;

  // One row of the directed table. Rows with hand_checked set carry their
  // single expected result; all other rows are checked against the model.
  typedef struct packed {
    cmd_e                cmd;
    logic [WORD_W-1:0]   value;
    logic [SLOT_W-1:0]   slot;
    logic                hand_checked;
    status_e             status;
    logic [WORD_W-1:0]   word;
    logic [POS_W-1:0]    position;
  } stim_row_t;

  // Drive every input to a known value from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i       = '0;
  logic [WORD_W-1:0]    value_i     = '0;
  logic [SLOT_W-1:0]    slot_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [WORD_W-1:0]    word_o;
  logic [POS_W-1:0]     position_o;
  logic                 last_o;

  always #HALF_PERIOD clk_i = ~clk_i;

  bounded_lifo_stack u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .slot_i      (slot_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .word_o      (word_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  // ---------------------------------------------------------------------
  // Stack model: its own copy of the entries and the fill count, plus the
  // queue of results still owed by the block, oldest first.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] stack_words [DEPTH];
  int                stack_fill = 0;
  stack_result_t     pending_results [$];

  int items_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int peak_fill      = 0;
  int display_cnt    = 0;
  int overflow_cnt   = 0;
  int underflow_cnt  = 0;
  int badindex_cnt   = 0;
  int empty_cnt      = 0;

  // Apply one accepted item to the model and queue the results it causes.
  task automatic model_stack_op(input cmd_e cmd, input logic [WORD_W-1:0] value,
                                input logic [SLOT_W-1:0] slot);
    stack_result_t res;
    int            idx;
    begin
      res.status   = ST_OK;
      res.word     = '0;
      res.position = '0;
      res.is_last  = 1'b1;
      case (cmd)
        CMD_PUSH: begin
          if (stack_fill >= DEPTH) begin
            res.status = ST_OVERFLOW;
            overflow_cnt++;
          end else begin
            stack_words[stack_fill] = value;
            res.word     = value;
            res.position = POS_W'(stack_fill);
            stack_fill++;
          end
          pending_results.push_back(res);
        end
        CMD_POP: begin
          if (stack_fill == 0) begin
            res.status = ST_UNDERFLOW;
            underflow_cnt++;
          end else begin
            stack_fill--;
            res.word     = stack_words[stack_fill];
            res.position = POS_W'(stack_fill);
          end
          pending_results.push_back(res);
        end
        CMD_MODIFY: begin
          // Only occupied slots may be written; anything at or above the
          // fill count, including slots past the depth, is refused.
          if (int'(slot) < stack_fill) begin
            stack_words[slot] = value;
            res.word     = value;
            res.position = slot;
          end else begin
            res.status = ST_BADINDEX;
            badindex_cnt++;
          end
          pending_results.push_back(res);
        end
        default: begin
          display_cnt++;
          if (stack_fill == 0) begin
            res.status = ST_EMPTY;
            empty_cnt++;
            pending_results.push_back(res);
          end else begin
            // Stream top to bottom; only the bottom entry closes the item.
            for (idx = stack_fill - 1; idx >= 0; idx--) begin
              res.word     = stack_words[idx];
              res.position = POS_W'(idx);
              res.is_last  = (idx == 0);
              pending_results.push_back(res);
            end
          end
        end
      endcase
      if (stack_fill > peak_fill) peak_fill = stack_fill;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. Payload is
  // set at the falling edge and held until the rising edge that takes it.
  // ---------------------------------------------------------------------
  task automatic send_item(input cmd_e cmd, input logic [WORD_W-1:0] value,
                           input logic [SLOT_W-1:0] slot, input logic hand_checked,
                           input stack_result_t given);
    int gap;
    begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        // Leave some burst boundaries without a gap at all.
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clk_i);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      cmd_i      <= cmd;
      value_i    <= value;
      slot_i     <= slot;
      // Hold until the block stops stalling at a rising edge.
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      items_accepted++;
      model_stack_op(cmd, value, slot);
      // Hand-checked rows swap the model's single result for the typed one.
      if (hand_checked) begin
        void'(pending_results.pop_back());
        pending_results.push_back(given);
      end
    end
  endtask

  // Mostly random words, with the extremes mixed in now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, switching mode every stretch:
  // never, sparse, alternate cycles, or mostly stalled.
  // ---------------------------------------------------------------------
  initial begin : receiver_stall
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ~out_stall_i;
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest one owed.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status   = status_e'(status_o);
      got.word     = word_o;
      got.position = position_o;
      got.is_last  = last_o;
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("cycle %0d: result with nothing pending: %s %0d word %08h pos %0d last %0b",
                   cycle_count, "status", got.status, got.word, got.position,
                   got.is_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("cycle %0d: expected status %0d word %08h pos %0d last %0b",
                     cycle_count, want.status, want.word, want.position, want.is_last);
            $display("          got      status %0d word %08h pos %0d last %0b",
                     got.status, got.word, got.position, got.is_last);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("FAIL bounded_lifo_stack");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then a fill to the brim, then a random mix.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t         dir_table [DIR_ROWS];
    stack_result_t     given;
    int                row;
    int                n;
    int                r;
    int                push_w;
    int                span;
    cmd_e              op;
    logic [SLOT_W-1:0] s;

    // Fields: cmd, value, slot, hand_checked, status, word, position.
    dir_table = '{
      // Empty stack: every access is an error or the empty status.
      '{CMD_DISPLAY, 32'h0000_0000, 6'd0,  1'b1, ST_EMPTY,     32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b1, ST_UNDERFLOW, 32'h0,         6'd0},
      '{CMD_MODIFY,  32'h1234_5678, 6'd0,  1'b1, ST_BADINDEX,  32'h0,         6'd0},
      '{CMD_MODIFY,  32'hffff_ffff, 6'd63, 1'b1, ST_BADINDEX,  32'h0,         6'd0},
      // Push the word extremes onto the bottom two slots.
      '{CMD_PUSH,    32'h7fff_ffff, 6'd0,  1'b1, ST_OK,        32'h7fff_ffff, 6'd0},
      '{CMD_PUSH,    32'h8000_0000, 6'd63, 1'b1, ST_OK,        32'h8000_0000, 6'd1},
      // Modify exactly at the fill count: one past the top.
      '{CMD_MODIFY,  32'h0bad_0bad, 6'd2,  1'b1, ST_BADINDEX,  32'h0,         6'd0},
      '{CMD_PUSH,    32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_PUSH,    32'hffff_ffff, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_PUSH,    32'h5555_5555, 6'd21, 1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_PUSH,    32'haaaa_aaaa, 6'd42, 1'b0, ST_OK,        32'h0,         6'd0},
      // Modify the bottom, slot 4 and the top of the occupied range, then one past the top.
      '{CMD_MODIFY,  32'h0000_0001, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_MODIFY,  32'hdead_beef, 6'd4,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_MODIFY,  32'hc001_d00d, 6'd5,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_MODIFY,  32'h0f0f_0f0f, 6'd6,  1'b1, ST_BADINDEX,  32'h0,         6'd0},
      '{CMD_DISPLAY, 32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_DISPLAY, 32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b0, ST_OK,        32'h0,         6'd0},
      // Drained again: underflow, then the empty display.
      '{CMD_POP,     32'h0000_0000, 6'd0,  1'b1, ST_UNDERFLOW, 32'h0,         6'd0},
      '{CMD_DISPLAY, 32'h0000_0000, 6'd0,  1'b1, ST_EMPTY,     32'h0,         6'd0}
    };

    // Hold reset for the first cycles, release it at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    for (row = 0; row < DIR_ROWS; row++) begin
      given.status   = dir_table[row].status;
      given.word     = dir_table[row].word;
      given.position = dir_table[row].position;
      given.is_last  = 1'b1;
      send_item(dir_table[row].cmd, dir_table[row].value, dir_table[row].slot,
                dir_table[row].hand_checked, given);
    end

    // Fill to the brim, push past it, show the full stack, touch the top
    // slot and the highest slot; the random mix then works down from full.
    while (stack_fill < DEPTH)
      send_item(CMD_PUSH, pick_word(), SLOT_W'($urandom()), 1'b0, '0);
    repeat (2) send_item(CMD_PUSH, pick_word(), SLOT_W'($urandom()), 1'b0, '0);
    send_item(CMD_DISPLAY, pick_word(), SLOT_W'($urandom()), 1'b0, '0);
    send_item(CMD_MODIFY, pick_word(), SLOT_W'(DEPTH - 1), 1'b0, '0);
    send_item(CMD_MODIFY, pick_word(), SLOT_W'(63), 1'b0, '0);

    // Random mix. Favor pushes while shallow so pops, modifies and displays
    // mostly see real content; modify aims mostly inside the occupied range.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      push_w = (stack_fill < DEPTH / 4) ? 50 : 30;
      span   = 100 - push_w;
      r      = $urandom_range(0, 99);
      if (r < push_w)                           op = CMD_PUSH;
      else if (r - push_w < span * 40 / 100)    op = CMD_POP;
      else if (r - push_w < span * 75 / 100)    op = CMD_MODIFY;
      else                                      op = CMD_DISPLAY;
      if (stack_fill > 0 && $urandom_range(0, 4) != 0)
        s = SLOT_W'($urandom_range(0, stack_fill - 1));
      else
        s = SLOT_W'($urandom_range(0, 63));
      send_item(op, pick_word(), s, 1'b0, '0);
    end

    // Drop valid after the last item, wait for every owed result, then keep
    // watching through a drain period to catch stray results.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items (%0d displays), %0d results checked, peak fill %0d of %0d",
             items_accepted, display_cnt, results_seen, peak_fill, DEPTH);
    $display("error paths hit: %0d overflow, %0d underflow, %0d bad index, %0d empty display",
             overflow_cnt, underflow_cnt, badindex_cnt, empty_cnt);
    if (mismatches == 0) begin
      $display("PASS bounded_lifo_stack");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL bounded_lifo_stack");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/blifo_pkg.sv
hw/rtl/blifo_ram.sv
hw/rtl/blifo_ctrl.sv
hw/rtl/bounded_lifo_stack.sv
tb/bounded_lifo_stack_tb.sv
